// File: rtl/cclim_pkg.sv
// Shared types, register indexes and constants of the chassis current power limiter.
package cclim_pkg;

  localparam int unsigned CUR_W  = 16;
  localparam int unsigned SUM_W  = 18;
  localparam int unsigned QUO_W  = 16;
  localparam int unsigned PROD_W = 37;
  localparam int unsigned CFG_W  = 17;
  localparam int unsigned IDX_W  = 3;

  localparam logic [13:0] POWER_LOW   = 14'd200;
  localparam logic [17:0] STEP_HI_GAP = 18'd2000;
  localparam logic [17:0] STEP_LO_GAP = 18'd1000;
  localparam logic [18:0] COEF_HI     = 19'd99;
  localparam logic [18:0] COEF_LO     = 19'd49;
  localparam logic [17:0] DIV_HI      = 18'd100;
  localparam logic [17:0] DIV_LO      = 18'd50;

  typedef enum logic [IDX_W-1:0] {
    REG_BUFFER_THRESHOLD = 3'd0,
    REG_POWER_OFFSET     = 3'd1,
    REG_FACTOR_BASE      = 3'd2,
    REG_FACTOR_SLOPE     = 3'd3,
    REG_CURRENT_CAP      = 3'd4,
    REG_SLEW_SUM         = 3'd5,
    REG_COUNT_LIMIT      = 3'd6,
    REG_CAP_VOLT_MIN     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] req_front_left;
    logic signed [15:0] req_front_right;
    logic signed [15:0] req_back_left;
    logic signed [15:0] req_back_right;
    logic [9:0]         energy_buffer;
    logic [13:0]        power_tenths;
    logic               cap_releasing;
    logic [11:0]        cap_volt;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_front_left;
    logic signed [15:0] out_front_right;
    logic signed [15:0] out_back_left;
    logic signed [15:0] out_back_right;
    logic               unlimited;
  } out_item_t;

  // Request to the shared multiply-divide unit: q = trunc((a*b + c) / divisor).
  typedef struct packed {
    logic               start;
    logic signed [16:0] a;
    logic [SUM_W:0]     b;
    logic signed [16:0] c;
    logic [SUM_W-1:0]   divisor;
  } md_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] q;
  } md_rsp_t;

endpackage

// File: rtl/cclim_muldiv.sv
// Shared multiply-add then restoring divide unit, one quotient bit per cycle.
module cclim_muldiv import cclim_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  md_req_t req_i,
  output md_rsp_t rsp_o
);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_DIV  = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [3:0]              cnt_q, cnt_d;
  logic signed [16:0]      a_q, c_q;
  logic [SUM_W:0]          b_q;
  logic [SUM_W-1:0]        div_q;
  logic [SUM_W-1:0]        rem_q, rem_d;
  logic [QUO_W-1:0]        quo_q, quo_d;
  logic                    neg_q, neg_d;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]       mag;
  logic [SUM_W:0]          trial;
  logic [SUM_W:0]          diff;
  logic                    take;

  assign prod = PROD_W'($signed(a_q) * $signed({1'b0, b_q})) + PROD_W'(c_q);
  assign mag  = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign take  = trial >= {1'b0, div_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    neg_d   = neg_q;
    rsp_o.done = 1'b0;
    unique case (state_q)
      U_IDLE: begin
        if (req_i.start) state_d = U_MUL;
      end
      U_MUL: begin
        // Top bits stay below the divisor, since the quotient fits QUO_W bits.
        neg_d   = prod[PROD_W-1];
        rem_d   = mag[QUO_W +: SUM_W];
        quo_d   = mag[QUO_W-1:0];
        cnt_d   = '0;
        state_d = U_DIV;
      end
      U_DIV: begin
        rem_d = take ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], take};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(QUO_W - 1)) begin
          rsp_o.done = 1'b1;
          state_d    = U_IDLE;
        end
      end
      default: state_d = U_IDLE;
    endcase
    // Present the quotient including the bit formed in this cycle.
    rsp_o.q = neg_q ? -$signed(quo_d) : $signed(quo_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == U_IDLE && req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      c_q   <= req_i.c;
      div_q <= req_i.divisor;
    end
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

endmodule

// File: rtl/chassis_current_power_limiter.sv
// Top level of the chassis current power limiter: registers, sequencer and result register.
// One control tick is one input beat and gives one output beat. A tick in unlimited
// mode goes from acceptance straight to the done state and the output register; a
// limited tick passes a prepare state, a scaling pass over all four wheels if scaling
// applies, a slew check and a slew pass over all four wheels if slewing applies. The
// time is set by the single shared multiply-divide unit: an issue state, a multiply-add
// state, then a restoring divide that yields one quotient bit per cycle, used for the
// wheels in turn. The input is not ready while a tick is in work; a finished result
// waits in the output register while the next tick is taken. Configuration writes are
// registered directly and must only be issued while the block is idle.
module chassis_current_power_limiter import cclim_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_PREP     = 3'd1;
  localparam logic [2:0] ST_SCL_GO   = 3'd2;
  localparam logic [2:0] ST_SCL_WAIT = 3'd3;
  localparam logic [2:0] ST_SLW_CHK  = 3'd4;
  localparam logic [2:0] ST_SLW_GO   = 3'd5;
  localparam logic [2:0] ST_SLW_WAIT = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  // Configuration registers
  logic [7:0]  thr_q;
  logic [13:0] poff_q;
  logic [15:0] fbase_q;
  logic [9:0]  fslope_q;
  logic [16:0] cap_q;
  logic [16:0] slew_q;
  logic [7:0]  climit_q;
  logic [11:0] vmin_q;

  // Persistent tick state
  logic signed [15:0] last_q [4];
  logic [7:0]         zcnt_q;
  logic               unl_q;

  // Work registers
  logic [2:0]         state_q, state_d;
  logic [1:0]         idx_q;
  in_item_t           item_q;
  logic signed [15:0] res_q [4];
  logic [SUM_W-1:0]   sum_q;
  logic [SUM_W-1:0]   fac_q;
  logic               hi_q;
  logic               out_valid_q;
  out_item_t          out_q;

  md_req_t            md_req;
  md_rsp_t            md_rsp;

  logic signed [15:0] cur [4];
  logic [16:0]        cmag [4];
  logic [SUM_W-1:0]   sum_c;
  logic signed [19:0] lhs, rhs;
  logic [13:0]        excess;
  logic               buf_scale;
  logic [20:0]        fraw;
  logic [SUM_W-1:0]   fmin;
  logic               cap_cond;
  logic               do_scale;
  logic [8:0]         zcnt_inc;
  logic               unl_next;
  logic [7:0]         zcnt_next;
  logic [16:0]        lmag;
  logic signed [16:0] ladj;
  logic signed [17:0] gap;
  logic [17:0]        gap_mag;
  logic               accept;
  logic               out_free;

  cclim_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  assign cur[0] = item_q.req_front_left;
  assign cur[1] = item_q.req_front_right;
  assign cur[2] = item_q.req_back_left;
  assign cur[3] = item_q.req_back_right;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cmag[i] = cur[i][15] ? 17'(-$signed({cur[i][15], cur[i]})) : {1'b0, cur[i]};
    end
  end
  assign sum_c = SUM_W'(cmag[0]) + SUM_W'(cmag[1]) + SUM_W'(cmag[2]) + SUM_W'(cmag[3]);

  // Buffer scaling applies when 100*buffer minus excess power falls under 100*threshold.
  assign excess    = (item_q.power_tenths > poff_q) ? item_q.power_tenths - poff_q : '0;
  assign lhs       = $signed(20'(item_q.energy_buffer) * 20'd100) - $signed(20'(excess));
  assign rhs       = $signed(20'(thr_q) * 20'd100);
  assign buf_scale = lhs < rhs;
  assign fraw      = 21'(fbase_q) + 21'(fslope_q) * 21'(item_q.energy_buffer);
  assign fmin      = (fraw > 21'(sum_c)) ? sum_c : SUM_W'(fraw);
  assign cap_cond  = !item_q.cap_releasing || (item_q.cap_volt < vmin_q);
  assign do_scale  = buf_scale ? (sum_c != '0) : (cap_cond && (sum_c > SUM_W'(cap_q)));

  // Zero-buffer tracking, evaluated on the accepted beat.
  assign zcnt_inc = {1'b0, zcnt_q} + 9'd1;
  always_comb begin
    unl_next  = unl_q;
    zcnt_next = zcnt_q;
    if (in_i.energy_buffer != '0) begin
      unl_next  = 1'b0;
      zcnt_next = '0;
    end else if (in_i.power_tenths < POWER_LOW) begin
      if (zcnt_inc > {1'b0, climit_q}) begin
        unl_next  = 1'b1;
        zcnt_next = '0;
      end else begin
        zcnt_next = zcnt_inc[7:0];
      end
    end
  end

  // Last value takes the sign of the current wheel's result; positive saturates.
  assign lmag = last_q[idx_q][15] ? 17'(-$signed({last_q[idx_q][15], last_q[idx_q]}))
                                  : {1'b0, last_q[idx_q]};
  assign ladj = (res_q[idx_q] > 16'sd0) ? ((lmag > 17'd32767) ? 17'sd32767 : $signed(lmag))
                                        : -$signed(lmag);
  assign gap     = 18'(res_q[idx_q]) - 18'(ladj);
  assign gap_mag = gap[17] ? 18'(-gap) : 18'(gap);

  always_comb begin
    md_req = '0;
    if (state_q == ST_SCL_GO) begin
      md_req.start   = 1'b1;
      md_req.a       = 17'(cur[idx_q]);
      md_req.b       = {1'b0, fac_q};
      md_req.c       = '0;
      md_req.divisor = sum_q;
    end else if (state_q == ST_SLW_GO) begin
      md_req.start   = 1'b1;
      md_req.a       = ladj;
      md_req.b       = hi_q ? COEF_HI : COEF_LO;
      md_req.c       = 17'(res_q[idx_q]);
      md_req.divisor = hi_q ? DIV_HI : DIV_LO;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (accept) state_d = unl_next ? ST_DONE : ST_PREP;
      ST_PREP:     state_d = do_scale ? ST_SCL_GO : ST_SLW_CHK;
      ST_SCL_GO:   state_d = ST_SCL_WAIT;
      ST_SCL_WAIT: begin
        if (md_rsp.done) state_d = (idx_q == 2'd3) ? ST_SLW_CHK : ST_SCL_GO;
      end
      ST_SLW_CHK: begin
        if (sum_q > SUM_W'(slew_q) && gap_mag > STEP_LO_GAP) state_d = ST_SLW_GO;
        else state_d = ST_DONE;
      end
      ST_SLW_GO:   state_d = ST_SLW_WAIT;
      ST_SLW_WAIT: begin
        if (md_rsp.done) state_d = (idx_q == 2'd3) ? ST_DONE : ST_SLW_GO;
      end
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= 8'd20;
      poff_q      <= 14'd700;
      fbase_q     <= 16'd2500;
      fslope_q    <= 10'd192;
      cap_q       <= 17'd14500;
      slew_q      <= 17'd11000;
      climit_q    <= 8'd200;
      vmin_q      <= 12'd1200;
      for (int i = 0; i < 4; i++) last_q[i] <= '0;
      zcnt_q      <= '0;
      unl_q       <= 1'b0;
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_BUFFER_THRESHOLD: thr_q    <= cfg_wdata_i[7:0];
          REG_POWER_OFFSET:     poff_q   <= cfg_wdata_i[13:0];
          REG_FACTOR_BASE:      fbase_q  <= cfg_wdata_i[15:0];
          REG_FACTOR_SLOPE:     fslope_q <= cfg_wdata_i[9:0];
          REG_CURRENT_CAP:      cap_q    <= cfg_wdata_i;
          REG_SLEW_SUM:         slew_q   <= cfg_wdata_i;
          REG_COUNT_LIMIT:      climit_q <= cfg_wdata_i[7:0];
          REG_CAP_VOLT_MIN:     vmin_q   <= cfg_wdata_i[11:0];
          default: ;
        endcase
      end
      state_q <= state_d;
      if (accept) begin
        zcnt_q <= zcnt_next;
        unl_q  <= unl_next;
      end
      // Advance the wheel index as each unit result comes back; clear on entry.
      if (state_q == ST_PREP) idx_q <= '0;
      else if (state_q == ST_SLW_CHK) idx_q <= '0;
      else if (md_rsp.done) idx_q <= idx_q + 2'd1;
      // Commit the new last values for limited ticks only.
      if (state_q == ST_DONE && out_free && !unl_q) begin
        for (int i = 0; i < 4; i++) last_q[i] <= res_q[i];
      end
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_i;
    if (state_q == ST_PREP) begin
      sum_q <= sum_c;
      fac_q <= buf_scale ? fmin : SUM_W'(cap_q);
      for (int i = 0; i < 4; i++) res_q[i] <= cur[i];
    end
    if (state_q == ST_SLW_CHK) hi_q <= gap_mag > STEP_HI_GAP;
    if ((state_q == ST_SCL_WAIT || state_q == ST_SLW_WAIT) && md_rsp.done) begin
      res_q[idx_q] <= md_rsp.q;
    end
    if (state_q == ST_DONE && out_free) begin
      if (unl_q) begin
        out_q.out_front_left  <= cur[0];
        out_q.out_front_right <= cur[1];
        out_q.out_back_left   <= cur[2];
        out_q.out_back_right  <= cur[3];
      end else begin
        out_q.out_front_left  <= res_q[0];
        out_q.out_front_right <= res_q[1];
        out_q.out_back_left   <= res_q[2];
        out_q.out_back_right  <= res_q[3];
      end
      out_q.unlimited <= unl_q;
    end
  end

endmodule

// File: test/testbench.sv
// Self-checking testbench of the chassis current power limiter.
`timescale 1ns / 1ps

module testbench;
  import cclim_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  in_item_t         in_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_item_t        out_o;

  chassis_current_power_limiter u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .in_i, .out_valid_o, .out_ready_i, .out_o
  );

  localparam int unsigned LIMIT_CYCLES = 2_000_000;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Predictor copy of the configuration and of the block state.
  int unsigned lim_thresh, lim_offset, lim_base, lim_slope;
  int unsigned lim_cap, lim_slew, lim_count_max, lim_volt_min;
  int          prev_cur[4];
  int unsigned zero_run;
  bit          free_run;

  in_item_t  tick_queue[$];
  out_item_t limited_queue[$];
  int unsigned mismatches = 0;
  int unsigned beats_out = 0;
  int unsigned free_beats = 0;
  int unsigned cycles = 0;
  bit          hold_sink = 1'b0;
  bit          pause_src = 1'b0;
  int unsigned sink_hold_cycles = 0;

  function automatic int absval(int v);
    return v < 0 ? -v : v;
  endfunction

  // Compute the limited currents of one tick and advance the predictor state.
  function automatic out_item_t limit_tick(in_item_t t);
    out_item_t r;
    int cur[4];
    int sum, excess, d, m;
    longint f;
    cur[0] = t.req_front_left;
    cur[1] = t.req_front_right;
    cur[2] = t.req_back_left;
    cur[3] = t.req_back_right;
    if (t.energy_buffer != 0) begin
      zero_run = 0;
      free_run = 1'b0;
    end else if (t.power_tenths < 200) begin
      if (zero_run + 1 > lim_count_max) begin
        zero_run = 0;
        free_run = 1'b1;
      end else begin
        zero_run = zero_run + 1;
      end
    end
    if (free_run) begin
      r.out_front_left = t.req_front_left;
      r.out_front_right = t.req_front_right;
      r.out_back_left = t.req_back_left;
      r.out_back_right = t.req_back_right;
      r.unlimited = 1'b1;
      return r;
    end
    sum = 0;
    for (int i = 0; i < 4; i++) sum += absval(cur[i]);
    excess = int'(t.power_tenths) - int'(lim_offset);
    if (excess < 0) excess = 0;
    if (100 * int'(t.energy_buffer) - excess < 100 * int'(lim_thresh)) begin
      f = longint'(lim_base) + longint'(lim_slope) * longint'(t.energy_buffer);
      if (f > sum) f = sum;
      for (int i = 0; i < 4; i++)
        cur[i] = (sum == 0) ? 0 : int'((longint'(cur[i]) * f) / sum);
    end else if (!t.cap_releasing || t.cap_volt < lim_volt_min) begin
      if (sum > int'(lim_cap))
        for (int i = 0; i < 4; i++)
          cur[i] = int'((longint'(cur[i]) * longint'(lim_cap)) / sum);
    end
    if (sum > int'(lim_slew)) begin
      for (int i = 0; i < 4; i++) begin
        m = absval(prev_cur[i]);
        if (cur[i] > 0) prev_cur[i] = (m > 32767) ? 32767 : m;
        else prev_cur[i] = -m;
      end
      d = absval(cur[0] - prev_cur[0]);
      if (d > 2000) begin
        for (int i = 0; i < 4; i++) cur[i] = (99 * prev_cur[i] + cur[i]) / 100;
      end else if (d > 1000) begin
        for (int i = 0; i < 4; i++) cur[i] = (49 * prev_cur[i] + cur[i]) / 50;
      end
    end
    for (int i = 0; i < 4; i++) prev_cur[i] = cur[i];
    r.out_front_left = 16'(cur[0]);
    r.out_front_right = 16'(cur[1]);
    r.out_back_left = 16'(cur[2]);
    r.out_back_right = 16'(cur[3]);
    r.unlimited = 1'b0;
    return r;
  endfunction

  function automatic int unsigned gap_len();
    // Mostly short gaps, now and then a long one, often none.
    int unsigned p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // Driver: offer queued ticks, hold valid and payload until the beat is taken.
  int unsigned src_gap = 0;
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      limited_queue.push_back(limit_tick(in_i));
      src_gap = gap_len();
    end
    if (!in_valid_i || in_ready_o) begin
      if (src_gap == 0 && !pause_src && tick_queue.size() > 0) begin
        in_i <= tick_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
        if (src_gap > 0) src_gap--;
      end
    end
  end

  // Monitor: compare every output beat with the oldest expectation.
  int unsigned sink_gap = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("chassis_current_power_limiter test failed");
      $finish;
    end
    if (out_valid_o && out_ready_i) begin
      beats_out++;
      if (out_o.unlimited) free_beats++;
      if (limited_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_o);
      end else begin
        out_item_t e;
        e = limited_queue.pop_front();
        if (e !== out_o) begin
          mismatches++;
          if (mismatches <= 10) $display("beat %0d: expected %p got %p", beats_out, e, out_o);
        end
      end
      sink_gap = gap_len();
    end
    if (sink_hold_cycles > 0) begin
      sink_hold_cycles--;
      out_ready_i <= 1'b0;
    end else if (hold_sink) begin
      // Take the hold request, clear it at once and count the stretch down.
      sink_hold_cycles = 400;
      hold_sink = 1'b0;
      out_ready_i <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic in_item_t rand_tick();
    in_item_t t;
    int unsigned p;
    t = in_item_t'(101'({$urandom, $urandom, $urandom, $urandom}));
    p = $urandom_range(9);
    // Bias toward small buffers and low power so both scaling paths and
    // the zero buffer count are exercised.
    if (p < 3) t.energy_buffer = 10'($urandom_range(0, 40));
    if (p == 3) t.energy_buffer = '0;
    if (p < 5) t.power_tenths = 14'($urandom_range(0, 1500));
    if ($urandom_range(3) == 0) begin
      t.req_front_left = 16'(int'($urandom_range(0, 8000)) - 4000);
      t.req_front_right = 16'(int'($urandom_range(0, 8000)) - 4000);
    end
    return t;
  endfunction

  task automatic wait_drained();
    while (tick_queue.size() > 0 || in_valid_i || limited_queue.size() > 0)
      @(negedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CFG_W'(val);
    case (idx)
      REG_BUFFER_THRESHOLD: lim_thresh = val & 'hFF;
      REG_POWER_OFFSET:     lim_offset = val & 'h3FFF;
      REG_FACTOR_BASE:      lim_base = val & 'hFFFF;
      REG_FACTOR_SLOPE:     lim_slope = val & 'h3FF;
      REG_CURRENT_CAP:      lim_cap = val & 'h1FFFF;
      REG_SLEW_SUM:         lim_slew = val & 'h1FFFF;
      REG_COUNT_LIMIT:      lim_count_max = val & 'hFF;
      default:              lim_volt_min = val & 'hFFF;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(int unsigned th, int unsigned off, int unsigned base,
                         int unsigned slope, int unsigned cap, int unsigned slew,
                         int unsigned cnt, int unsigned vmin);
    write_reg(REG_BUFFER_THRESHOLD, th);
    write_reg(REG_POWER_OFFSET, off);
    write_reg(REG_FACTOR_BASE, base);
    write_reg(REG_FACTOR_SLOPE, slope);
    write_reg(REG_CURRENT_CAP, cap);
    write_reg(REG_SLEW_SUM, slew);
    write_reg(REG_COUNT_LIMIT, cnt);
    write_reg(REG_CAP_VOLT_MIN, vmin);
  endtask

  function automatic in_item_t mk(int fl, int fr, int bl, int br, int buf_j,
                                  int pwr, bit rel, int volt);
    in_item_t t;
    t.req_front_left = 16'(fl);
    t.req_front_right = 16'(fr);
    t.req_back_left = 16'(bl);
    t.req_back_right = 16'(br);
    t.energy_buffer = 10'(buf_j);
    t.power_tenths = 14'(pwr);
    t.cap_releasing = rel;
    t.cap_volt = 12'(volt);
    return t;
  endfunction

  initial begin
    lim_thresh = 20; lim_offset = 700; lim_base = 2500; lim_slope = 192;
    lim_cap = 14500; lim_slew = 11000; lim_count_max = 200; lim_volt_min = 1200;
    for (int i = 0; i < 4; i++) prev_cur[i] = 0;
    zero_run = 0;
    free_run = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: zero sum, extremes, both scaling paths, both slew steps.
    tick_queue.push_back(mk(0, 0, 0, 0, 5, 0, 0, 0));
    tick_queue.push_back(mk(-32768, -32768, -32768, -32768, 5, 16383, 0, 0));
    tick_queue.push_back(mk(32767, 32767, 32767, 32767, 1023, 0, 0, 4095));
    tick_queue.push_back(mk(32767, -32768, 100, -100, 1023, 0, 1, 4095));
    tick_queue.push_back(mk(9000, 9000, -9000, 9000, 1023, 16383, 1, 100));
    tick_queue.push_back(mk(5000, 3000, 3000, 3000, 1023, 0, 1, 4095));
    tick_queue.push_back(mk(3500, 3000, 3000, 3000, 1023, 0, 1, 4095));
    tick_queue.push_back(mk(-6000, 4000, -4000, 4000, 1023, 0, 1, 4095));
    tick_queue.push_back(mk(1000, -1000, 1000, 0, 0, 5000, 1, 2000));
    wait_drained();

    // Short count limit so unlimited mode is entered and left.
    set_all(255, 0, 65535, 1023, 131071, 0, 2, 4095);
    for (int i = 0; i < 5; i++) tick_queue.push_back(mk(-32768, 32767, 7, -7, 0, 199, 0, 0));
    tick_queue.push_back(mk(100, 100, 100, 100, 1, 0, 0, 0));
    tick_queue.push_back(mk(100, 100, 100, 100, 0, 200, 0, 0));
    wait_drained();

    // Random phases through several settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_all(20, 700, 2500, 192, 14500, 11000, 200, 1200);
        1: set_all(0, 16383, 0, 0, 0, 131071, 0, 0);
        2: set_all(255, 0, 65535, 1023, 131071, 0, 255, 4095);
        default: set_all($urandom_range(255), $urandom_range(16383), $urandom,
                         $urandom_range(1023), $urandom_range(131071),
                         $urandom_range(40000), $urandom_range(8), $urandom_range(4095));
      endcase
      for (int i = 0; i < 200; i++) begin
        if (ph == 1 && (i % 20) < 8) tick_queue.push_back(mk(1, -1, 2, 3, 0, 10, 1, 5));
        else tick_queue.push_back(rand_tick());
      end
      if (ph == 2) begin
        // Stall the sink for a long stretch while ticks keep arriving.
        hold_sink = 1'b1;
        wait (hold_sink == 1'b0);
      end
      if (ph == 4) begin
        // Pause the source until everything is out, then resume.
        repeat (2000) @(posedge clk_i);
        pause_src = 1'b1;
        @(negedge clk_i);
        while (in_valid_i || limited_queue.size() > 0) @(negedge clk_i);
        pause_src = 1'b0;
      end
      wait_drained();
    end

    $display("covered %0d output beats, %0d in unlimited mode, over 8 register settings",
             beats_out, free_beats);
    if (mismatches == 0) begin
      $display("chassis_current_power_limiter test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("chassis_current_power_limiter test failed");
    end
    $finish;
  end

endmodule
